/* design/gtpc_pkg.sv */
package gtpc_pkg;

  localparam int unsigned PosW = 32;
  localparam int unsigned AngFrac = 13;
  localparam int unsigned SpdFrac = 12;
  localparam int unsigned AngQ = 30;
  localparam int unsigned CordicIter = 16;
  localparam int unsigned CfgW = 31;
  localparam int unsigned CfgIdxW = 3;
  // datapath width: 33-bit differences grow by CORDIC gain
  localparam int unsigned DW = 36;
  localparam int unsigned ZW = 34;
  localparam logic signed [ZW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;

  typedef enum logic [1:0] {
    MODE_NEW = 2'd0,
    MODE_DRIVE = 2'd1,
    MODE_CIRCLE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_START = 2'd1,
    EV_END = 2'd2
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIUS = 3'd0,
    REG_ARRIVE_TOL = 3'd1,
    REG_HEAD_TOL = 3'd2,
    REG_TURN_RATE = 3'd3,
    REG_DRIVE_SPEED = 3'd4,
    REG_CIRCLE_SPEED = 3'd5,
    REG_CIRCLE_TURN = 3'd6,
    REG_CIRCLE_TICKS = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic [1:0] event_res;
    logic [31:0] episode;
    logic [1:0] mode;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [ZW-1:0] angle;
    logic [DW-1:0] xmag;
  } cordic_rsp_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    r = '0;
    case (i)
      5'd0: r = 34'sd843314857;
      5'd1: r = 34'sd497837829;
      5'd2: r = 34'sd263043837;
      5'd3: r = 34'sd133525159;
      5'd4: r = 34'sd67021687;
      5'd5: r = 34'sd33543516;
      5'd6: r = 34'sd16775851;
      5'd7: r = 34'sd8388437;
      5'd8: r = 34'sd4194283;
      5'd9: r = 34'sd2097149;
      default: r = ZW'(34'sd1073741824 >>> i);
    endcase
    return r;
  endfunction

endpackage

/* design/gtpc_stream_if.sv */
interface gtpc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

/* design/gtpc_cordic.sv */
// Vectoring CORDIC, one iteration per cycle. Shifts of the cross terms are
// carried out by barrel shifters on the x and y words, one per word.
module gtpc_cordic (
  input  logic clk_i,
  input  logic rst_ni,
  input  gtpc_pkg::cordic_req_t req_i,
  output gtpc_pkg::cordic_rsp_t rsp_o
);
  logic signed [gtpc_pkg::DW-1:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [gtpc_pkg::ZW-1:0] z_q, z_d;
  logic [4:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d;

  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q;
    busy_d = busy_q; done_d = 1'b0;
    if (req_i.start) begin
      it_d = '0;
      busy_d = 1'b1;
      if (req_i.dx < 0) begin
        x_d = -req_i.dx;
        y_d = -req_i.dy;
        z_d = (req_i.dy >= 0) ? gtpc_pkg::PiQ30 : -gtpc_pkg::PiQ30;
      end else begin
        x_d = req_i.dx;
        y_d = req_i.dy;
        z_d = '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + gtpc_pkg::atan_lut(it_q);
      end else if (y_q < 0) begin
        x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - gtpc_pkg::atan_lut(it_q);
      end
      it_d = it_q + 5'd1;
      if (it_q == 5'(gtpc_pkg::CordicIter - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.angle = z_q;
  assign rsp_o.xmag = (x_q < 0) ? '0 : x_q;
endmodule

/* design/go_to_point_then_circle_controller_unit.sv */
// Channel  | Dir | Payload
// in_if    | in  | pos_x, pos_y, heading, center_x, center_y
// out_if   | out | linear_cmd, angular_cmd, event_res, episode, mode
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// New-target and circle ticks: the result is formed on the input transfer, then S_OUT raises out_if.valid.
// Drive ticks: after the input transfer come 16 CORDIC iterations, a step to
// capture the CORDIC result, gain multiply split into two 18-bit partial
// products, heading-error wrap, decision, output register.
// One tick at a time; in_if.ready stays low from the input transfer until the
// cycle after the result transfer, so a stalled out_if holds the input off.
// Reset is asynchronous, active low, and restores register defaults.
module go_to_point_then_circle_controller_unit (
  input  logic clk_i,
  input  logic rst_ni,
  gtpc_stream_if.sink in_if,
  gtpc_stream_if.source out_if,
  input  logic cfg_we_i,
  input  logic [gtpc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [gtpc_pkg::CfgW-1:0] cfg_data_i
);
  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_MUL_LO, S_MUL_HI, S_WRAP, S_DECIDE, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [30:0] radius_q, arr_tol_q;
  logic [14:0] head_tol_q, turn_rate_q, drive_spd_q, circ_spd_q;
  logic signed [15:0] circ_turn_q;
  logic [15:0] circ_ticks_q;

  // controller state
  gtpc_pkg::mode_e mode_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic [15:0] elapsed_q;
  logic [31:0] episode_q;

  logic signed [15:0] heading_q;
  gtpc_pkg::out_item_t out_q;
  logic out_valid_q;

  gtpc_pkg::cordic_req_t creq;
  gtpc_pkg::cordic_rsp_t crsp;

  // distance product: xmag (36 b) * 30-bit gain, split at bit 18 of xmag
  logic [gtpc_pkg::DW-1:0] xmag_q;
  logic [65:0] prod_q;
  logic [47:0] pp;
  logic [gtpc_pkg::DW-1:0] range_w;
  logic signed [gtpc_pkg::ZW+1:0] err_q, err_wrap;
  logic signed [gtpc_pkg::ZW+1:0] pi_w, tol_w;
  logic signed [gtpc_pkg::ZW+3:0] steer;
  logic signed [gtpc_pkg::ZW+3:0] steer_sh;
  logic signed [15:0] steer_sat;
  logic signed [32:0] sx_sum;

  function automatic gtpc_pkg::out_item_t make_out(input logic signed [15:0] lin,
                                                   input logic signed [15:0] ang,
                                                   input gtpc_pkg::event_e ev,
                                                   input logic [31:0] epi,
                                                   input gtpc_pkg::mode_e md);
    gtpc_pkg::out_item_t r;
    r.linear_cmd = lin;
    r.angular_cmd = ang;
    r.event_res = ev;
    r.episode = epi;
    r.mode = md;
    return r;
  endfunction

  gtpc_cordic u_cordic (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(creq), .rsp_o(crsp));

  assign in_if.ready = (state_q == S_IDLE) && !out_valid_q;
  assign out_if.valid = out_valid_q;
  assign out_if.data = out_q;

  assign creq.start = (state_q == S_IDLE) && in_if.valid && in_if.ready
                      && (mode_q == gtpc_pkg::MODE_DRIVE);
  assign creq.dx = gtpc_pkg::DW'(33'(start_x_q) - 33'(in_if.data.pos_x));
  assign creq.dy = gtpc_pkg::DW'(33'(start_y_q) - 33'(in_if.data.pos_y));

  assign pp = (state_q == S_MUL_LO) ? 48'(xmag_q[17:0]) * 48'(gtpc_pkg::InvGainQ30)
                                    : 48'(xmag_q[35:18]) * 48'(gtpc_pkg::InvGainQ30);
  assign range_w = gtpc_pkg::DW'(prod_q >> 30);

  assign pi_w = (gtpc_pkg::ZW+2)'(gtpc_pkg::PiQ30);
  // heading input is within about 4 rad, so one 2*pi step suffices each way
  always_comb begin
    err_wrap = err_q;
    if (err_q > pi_w) err_wrap = err_q - (pi_w <<< 1);
    else if (err_q < -pi_w) err_wrap = err_q + (pi_w <<< 1);
  end
  assign tol_w = (gtpc_pkg::ZW+2)'($signed({1'b0, head_tol_q}))
                 <<< (gtpc_pkg::AngQ - gtpc_pkg::AngFrac);
  assign steer = (gtpc_pkg::ZW+4)'(err_q) * 3
                 + ((gtpc_pkg::ZW+4)'(1) <<< (gtpc_pkg::AngQ - gtpc_pkg::SpdFrac));
  assign steer_sh = steer >>> (gtpc_pkg::AngQ + 1 - gtpc_pkg::SpdFrac);
  assign steer_sat = (steer_sh > 32767) ? 16'sd32767 :
                     (steer_sh < -32768) ? -16'sd32768 : 16'(steer_sh);
  assign sx_sum = 33'(in_if.data.center_x) + $signed({2'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 31'd196608; arr_tol_q <= 31'd9830; head_tol_q <= 15'd1638;
      turn_rate_q <= 15'd2048; drive_spd_q <= 15'd2458; circ_spd_q <= 15'd2458;
      circ_turn_q <= 16'sd819; circ_ticks_q <= 16'd628;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gtpc_pkg::REG_RADIUS: radius_q <= cfg_data_i;
        gtpc_pkg::REG_ARRIVE_TOL: arr_tol_q <= cfg_data_i;
        gtpc_pkg::REG_HEAD_TOL: head_tol_q <= cfg_data_i[14:0];
        gtpc_pkg::REG_TURN_RATE: turn_rate_q <= cfg_data_i[14:0];
        gtpc_pkg::REG_DRIVE_SPEED: drive_spd_q <= cfg_data_i[14:0];
        gtpc_pkg::REG_CIRCLE_SPEED: circ_spd_q <= cfg_data_i[14:0];
        gtpc_pkg::REG_CIRCLE_TURN: circ_turn_q <= cfg_data_i[15:0];
        gtpc_pkg::REG_CIRCLE_TICKS: circ_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= gtpc_pkg::MODE_NEW;
      start_x_q <= '0; start_y_q <= '0;
      elapsed_q <= '0; episode_q <= 32'd1;
      out_valid_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          case (mode_q)
            gtpc_pkg::MODE_DRIVE: begin
              heading_q <= in_if.data.heading;
              state_q <= S_CORDIC;
            end
            gtpc_pkg::MODE_CIRCLE: begin
              if (elapsed_q < circ_ticks_q) begin
                out_q <= make_out($signed({1'b0, circ_spd_q}), circ_turn_q,
                                  gtpc_pkg::EV_NONE, 32'd0, gtpc_pkg::MODE_CIRCLE);
                elapsed_q <= elapsed_q + 16'd1;
              end else begin
                out_q <= make_out(16'sd0, 16'sd0, gtpc_pkg::EV_END, episode_q,
                                  gtpc_pkg::MODE_NEW);
                episode_q <= episode_q + 32'd1;
                mode_q <= gtpc_pkg::MODE_NEW;
              end
              state_q <= S_OUT;
            end
            default: begin
              start_x_q <= (sx_sum > 33'sd2147483647) ? 32'sh7FFFFFFF : 32'(sx_sum);
              start_y_q <= in_if.data.center_y;
              elapsed_q <= '0;
              out_q <= make_out(16'sd0, 16'sd0, gtpc_pkg::EV_START, 32'd0,
                                gtpc_pkg::MODE_DRIVE);
              mode_q <= gtpc_pkg::MODE_DRIVE;
              state_q <= S_OUT;
            end
          endcase
        end
        S_CORDIC: if (crsp.done) begin
          xmag_q <= crsp.xmag;
          err_q <= (gtpc_pkg::ZW+2)'(crsp.angle)
                   - ((gtpc_pkg::ZW+2)'(heading_q) <<< (gtpc_pkg::AngQ - gtpc_pkg::AngFrac));
          state_q <= S_MUL_LO;
        end
        S_MUL_LO: begin
          prod_q <= 66'(pp);
          state_q <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_q <= prod_q + (66'(pp) << 18);
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          err_q <= err_wrap;
          state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          if (range_w > gtpc_pkg::DW'(arr_tol_q)) begin
            if (err_q > tol_w || err_q < -tol_w) begin
              // turn in place toward the start point
              out_q <= make_out(16'sd0, (err_q > 0) ? $signed({1'b0, turn_rate_q})
                                                    : -$signed({1'b0, turn_rate_q}),
                                gtpc_pkg::EV_NONE, 32'd0, gtpc_pkg::MODE_DRIVE);
            end else begin
              out_q <= make_out($signed({1'b0, drive_spd_q}), steer_sat,
                                gtpc_pkg::EV_NONE, 32'd0, gtpc_pkg::MODE_DRIVE);
            end
          end else begin
            mode_q <= gtpc_pkg::MODE_CIRCLE;
            elapsed_q <= '0;
            out_q <= make_out(16'sd0, 16'sd0, gtpc_pkg::EV_NONE, 32'd0,
                              gtpc_pkg::MODE_CIRCLE);
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/gtpc_checker.sv */
module gtpc_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic [1:0] ev_i,
  input logic [1:0] mode_i,
  input logic [31:0] episode_i
);
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("input taken while result pending");
  a_start_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ev_i == gtpc_pkg::EV_START |-> mode_i == gtpc_pkg::MODE_DRIVE)
    else $error("start without drive");
  a_end_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ev_i == gtpc_pkg::EV_END |-> mode_i == gtpc_pkg::MODE_NEW && episode_i != 0)
    else $error("bad end");
  a_no_episode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ev_i != gtpc_pkg::EV_END |-> episode_i == 0) else $error("stray episode");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped");
endmodule

bind go_to_point_then_circle_controller_unit gtpc_props u_gtpc_props (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid_i(in_if.valid), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .ev_i(out_if.data.event_res), .mode_i(out_if.data.mode),
  .episode_i(out_if.data.episode)
);

/* bench/gtpc_checker.sv */
module gtpc_checker
  import gtpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  gtpc_stream_if in_mon,
  gtpc_stream_if out_mon,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output int fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Pi = 64'sd3373259426;

  // configuration copy
  logic [30:0] radius, arrive_tol;
  logic [14:0] head_tol, turn_rate, drive_speed, circle_speed;
  logic signed [15:0] circle_turn;
  logic [15:0] circle_ticks;
  // controller state
  mode_e mode_q;
  logic signed [31:0] start_x, start_y;
  logic [15:0] circle_elapsed;
  logic [31:0] episode_count;

  out_item_t expected_cmds[$];
  int fails;
  assign fail_count_o = fails;

  longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};

  task automatic report(string field, longint got, longint want);
    $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
    fails++;
  endtask

  // vectoring rotation: bearing in Q2.30, magnitude with gain removed
  function automatic void bearing_range(input longint dx, input longint dy,
                                        output longint ang, output longint unsigned rng);
    longint x, y, z, xs, ys;
    longint unsigned ux;
    x = dx;
    y = dy;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? Pi : -Pi;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    if (x < 0) x = 0;
    ux = x;
    ang = z;
    rng = (ux * 64'd652032874) >> 30;
  endfunction

  function automatic out_item_t next_command(input in_item_t it);
    out_item_t r;
    longint ang, err, tol, t;
    longint unsigned rng;
    r = '0;
    if (mode_q == MODE_DRIVE) begin
      bearing_range(longint'(start_x) - longint'(it.pos_x),
                    longint'(start_y) - longint'(it.pos_y), ang, rng);
      err = ang - longint'(it.heading) * (64'sd1 << 17);
      while (err > Pi) err -= 2 * Pi;
      while (err < -Pi) err += 2 * Pi;
      if (rng > longint'(arrive_tol)) begin
        tol = longint'(head_tol) * (64'sd1 << 17);
        if (err > tol || err < -tol) begin
          r.angular_cmd = (err > 0) ? 16'(turn_rate) : -16'(turn_rate);
        end else begin
          r.linear_cmd = 16'(drive_speed);
          t = (err * 3 + (64'sd1 << 18)) >>> 19;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          r.angular_cmd = 16'(t);
        end
      end else begin
        mode_q = MODE_CIRCLE;
        circle_elapsed = '0;
      end
    end else if (mode_q == MODE_CIRCLE) begin
      if (circle_elapsed < circle_ticks) begin
        r.linear_cmd = 16'(circle_speed);
        r.angular_cmd = circle_turn;
        circle_elapsed = circle_elapsed + 16'd1;
      end else begin
        r.event_res = EV_END;
        r.episode = episode_count;
        episode_count = episode_count + 32'd1;
        mode_q = MODE_NEW;
      end
    end else begin
      t = longint'(it.center_x) + longint'(radius);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      start_x = 32'(t);
      start_y = it.center_y;
      circle_elapsed = '0;
      r.event_res = EV_START;
      mode_q = MODE_DRIVE;
    end
    r.mode = mode_q;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t w;
    if (!rst_ni) begin
      radius <= 31'd196608; arrive_tol <= 31'd9830; head_tol <= 15'd1638;
      turn_rate <= 15'd2048; drive_speed <= 15'd2458; circle_speed <= 15'd2458;
      circle_turn <= 16'sd819; circle_ticks <= 16'd628;
      mode_q = MODE_NEW; start_x = '0; start_y = '0;
      circle_elapsed = '0; episode_count = 32'd1;
      expected_cmds.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_RADIUS: radius <= cfg_data_i;
          REG_ARRIVE_TOL: arrive_tol <= cfg_data_i;
          REG_HEAD_TOL: head_tol <= cfg_data_i[14:0];
          REG_TURN_RATE: turn_rate <= cfg_data_i[14:0];
          REG_DRIVE_SPEED: drive_speed <= cfg_data_i[14:0];
          REG_CIRCLE_SPEED: circle_speed <= cfg_data_i[14:0];
          REG_CIRCLE_TURN: circle_turn <= cfg_data_i[15:0];
          REG_CIRCLE_TICKS: circle_ticks <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) expected_cmds.push_back(next_command(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_cmds.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          w = expected_cmds.pop_front();
          if (out_mon.data.linear_cmd !== w.linear_cmd)
            report("linear_cmd", out_mon.data.linear_cmd, w.linear_cmd);
          if (out_mon.data.angular_cmd !== w.angular_cmd)
            report("angular_cmd", out_mon.data.angular_cmd, w.angular_cmd);
          if (out_mon.data.event_res !== w.event_res)
            report("event_res", out_mon.data.event_res, w.event_res);
          if (out_mon.data.episode !== w.episode)
            report("episode", out_mon.data.episode, w.episode);
          if (out_mon.data.mode !== w.mode)
            report("mode", out_mon.data.mode, w.mode);
        end
      end
    end
  end

  function automatic int pending();
    return expected_cmds.size();
  endfunction
endmodule

/* bench/testbench.sv */
module testbench;
  import gtpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;
  int fail_count;

  gtpc_stream_if #(.T(in_item_t)) in_ch ();
  gtpc_stream_if #(.T(out_item_t)) out_ch ();

  go_to_point_then_circle_controller_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch), .out_if(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  gtpc_checker checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Transfer counts; sent is bumped by the sender before it returns, so
  // the idle test can only lag, never see a false match.
  int sent = 0, taken = 0;
  int gap_in_max = 10, gap_out_max = 10;
  bit hold_off = 1'b0;
  // shadow of the registers the stimulus needs to aim at the start point
  longint sh_radius = 196608, sh_tol = 9830, sh_ticks = 628;
  longint sx, sy;

  initial in_ch.valid = 1'b0;
  initial in_ch.data = '0;
  initial out_ch.ready = 1'b0;

  // One long hold-off on the result side to back up the input.
  initial begin
    wait (taken >= 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Result side: random stall per result, plus the hold-off above.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(gap_out_max);
      if (gap > 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (hold_off) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      taken++;
    end
  end

  task automatic send(input in_item_t it);
    int gap;
    gap = $urandom_range(gap_in_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (taken != sent);
  endtask

  task automatic write_reg(input reg_idx_e idx, input longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CfgW'(val);
    @(posedge clk_i);
    case (idx)
      REG_RADIUS: sh_radius = val;
      REG_ARRIVE_TOL: sh_tol = val;
      REG_CIRCLE_TICKS: sh_ticks = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] any_heading();
    return 16'(int'($urandom_range(51472)) - 25736);
  endfunction

  function automatic in_item_t any_item();
    in_item_t it;
    it.pos_x = $urandom; it.pos_y = $urandom; it.heading = any_heading();
    it.center_x = $urandom; it.center_y = $urandom;
    return it;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic in_item_t at_offset(input longint dx, input longint dy,
                                         input logic signed [15:0] hd);
    in_item_t it;
    it = any_item();
    it.pos_x = clamp32(sx - dx);
    it.pos_y = clamp32(sy - dy);
    it.heading = hd;
    return it;
  endfunction

  // new-target tick; also tracks where the block will put the start point
  task automatic new_target(input logic signed [31:0] cx, input logic signed [31:0] cy);
    in_item_t it;
    longint t;
    it = any_item();
    it.center_x = cx;
    it.center_y = cy;
    t = longint'(cx) + sh_radius;
    sx = (t > 64'sd2147483647) ? 64'sd2147483647 : t;
    sy = cy;
    send(it);
  endtask

  function automatic longint far_off();
    longint m;
    m = $urandom_range(1 << 24, 1 << 22);
    return $urandom_range(1) ? m : -m;
  endfunction

  // One well-formed episode with random content: approach, arrive, circle, end.
  task automatic episode_run();
    logic signed [31:0] cx, cy;
    longint d;
    int n;
    cx = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(int'($urandom) >>> 1);
    cy = ($urandom_range(9) == 0) ? 32'($urandom) : 32'(int'($urandom) >>> 1);
    new_target(cx, cy);
    n = $urandom_range(12);
    repeat (n) begin
      case ($urandom_range(3))
        0: send(any_item());  // noise, almost surely far away
        1: begin
          // start point dead ahead at bearing 0, heading near it
          d = $urandom_range(1 << 24, 1 << 22);
          send(at_offset(d, 0, 16'(int'($urandom_range(6000)) - 3000)));
        end
        2: begin
          // start point straight up or down, heading near plus or minus pi/2
          d = far_off();
          send(at_offset(0, d, 16'((d > 0 ? 12868 : -12868)
                                   + int'($urandom_range(4000)) - 2000)));
        end
        default: send(at_offset(far_off(), far_off(), any_heading()));
      endcase
    end
    // arrival: exactly on the point or well inside the tolerance
    if ($urandom_range(1)) send(at_offset(0, 0, any_heading()));
    else send(at_offset($urandom_range(sh_tol / 4), -longint'($urandom_range(sh_tol / 4)),
                        any_heading()));
    repeat (sh_ticks + 1) send(any_item());
  endtask

  task automatic random_config();
    write_reg(REG_RADIUS, ($urandom_range(7) == 0) ? 64'h7FFFFFFF : $urandom_range(1 << 20));
    write_reg(REG_ARRIVE_TOL, $urandom_range(1 << 16));
    write_reg(REG_HEAD_TOL, $urandom_range(25736));
    write_reg(REG_TURN_RATE, $urandom_range(32767));
    write_reg(REG_DRIVE_SPEED, $urandom_range(32767));
    write_reg(REG_CIRCLE_SPEED, $urandom_range(32767));
    write_reg(REG_CIRCLE_TURN, $urandom_range(65535));
    write_reg(REG_CIRCLE_TICKS, $urandom_range(6));
    end_writes();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, default registers first.
    // Start point x saturates, then the largest possible differences.
    new_target(32'sh7FFFFFFF, 32'sh80000000);
    send(at_offset(sx - longint'(32'sh80000000), sy - 64'sd2147483647, 16'sd25736));
    // heading error right on the tolerance drives, one step past turns
    send(at_offset(1 << 20, 0, 16'sd1638));
    send(at_offset(1 << 20, 0, -16'sd1638));
    send(at_offset(1 << 20, 0, 16'sd1639));
    send(at_offset(1 << 20, 0, -16'sd1639));
    // bearing -pi/2 against heading +pi wraps
    send(at_offset(0, -(1 << 20), 16'sd25736));
    wait_idle();
    // distance of a 2^20 offset on the x axis after gain removal: exactly on tolerance
    write_reg(REG_ARRIVE_TOL, 636750);
    write_reg(REG_HEAD_TOL, 25736);
    write_reg(REG_TURN_RATE, 32767);
    write_reg(REG_DRIVE_SPEED, 32767);
    write_reg(REG_CIRCLE_SPEED, 0);
    write_reg(REG_CIRCLE_TURN, 16'h8000);
    write_reg(REG_CIRCLE_TICKS, 65535);
    write_reg(REG_RADIUS, 0);
    end_writes();
    send(at_offset(1 << 20, 0, 16'sd0));
    repeat (3) send(any_item());
    wait_idle();
    // zero circle ticks: the circle ends on the next tick
    write_reg(REG_CIRCLE_TICKS, 0);
    write_reg(REG_ARRIVE_TOL, 0);
    end_writes();
    send(any_item());
    // bearing pi against heading -pi, then arrive at distance zero
    new_target(32'sh80000000, 32'sd0);
    send(at_offset(-64'sd4294967295, 0, -16'sd25736));
    send(at_offset(0, 0, 16'sd0));
    send(any_item());
    wait_idle();
    // largest radius from the most negative centre
    write_reg(REG_RADIUS, 64'h7FFFFFFF);
    write_reg(REG_ARRIVE_TOL, 64'h7FFFFFFF);
    write_reg(REG_CIRCLE_TURN, 32767);
    write_reg(REG_CIRCLE_SPEED, 32767);
    write_reg(REG_HEAD_TOL, 0);
    write_reg(REG_TURN_RATE, 0);
    write_reg(REG_DRIVE_SPEED, 0);
    write_reg(REG_CIRCLE_TICKS, 1);
    end_writes();
    new_target(32'sh80000000, 32'sh7FFFFFFF);
    send(any_item());  // a random position, so the distance can exceed even the widest tolerance
    send(any_item());
    send(any_item());
    wait_idle();

    // Random part: phases of episodes under changing registers.
    while (sent < 1600) begin
      random_config();
      case ($urandom_range(3))
        0: begin gap_in_max = 0; gap_out_max = 0; end
        1: begin gap_in_max = 10; gap_out_max = 0; end
        default: begin gap_in_max = 10; gap_out_max = 10; end
      endcase
      repeat ($urandom_range(4, 1)) episode_run();
      wait_idle();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && checker_u.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
